/* src/hdbf_pkg.sv */
// hdbf_pkg: shared types and constants of the hashed domain bit filter
// no dependencies; imported by every module of the block

package hdbf_pkg;

   // default number of slots in the presence table (power of two)
   localparam int unsigned TABLE_SIZE_DEFAULT = 65536;

   // presence table is stored as rows of presence bits
   localparam int unsigned ROW_W     = 32;
   localparam int unsigned ROW_BIT_W = 5;

   // depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   // operation codes
   localparam logic OP_SEARCH = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   // one request: a character of a name
   typedef struct packed {
      logic [7:0] name_byte;
      logic       last_byte;
      logic       operation;
   } hdbf_req_type;

   // one result: membership of the slot tested
   typedef struct packed {
      logic        was_present;
      logic [15:0] slot_index;
   } hdbf_rsp_type;

   // status of the back end seen by the front
   typedef struct packed {
      logic clearing;
   } hdbf_status_type;

endpackage

/* src/hdbf_front.sv */
// hdbf_front: takes name bytes, keeps the running hash, queues a lookup per name
// depends on hdbf_pkg

module hdbf_front #(
   parameter int unsigned SLOT_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hdbf_pkg::hdbf_req_type   req_payload,
   input  logic                     q_full,
   input  hdbf_pkg::hdbf_status_type back_status,
   output logic                     push_valid,
   output logic [SLOT_W:0]          push_data
);
   import hdbf_pkg::*;

   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] hash_next;
   logic        accept;

   // no requests while the table is cleared or the queue is full
   assign req_stall = q_full || back_status.clearing;
   assign accept    = req_valid && !req_stall;

   // h = 37*h + byte, wrapping at 32 bits
   assign hash_next = (hash_ff << 5) + (hash_ff << 2) + hash_ff
                    + 32'(req_payload.name_byte);

   // hash returns to zero after the last byte of a name
   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = req_payload.last_byte ? '0 : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // last byte queues the slot and the operation
   assign push_valid = accept && req_payload.last_byte;
   assign push_data  = {req_payload.operation, hash_next[SLOT_W-1:0]};

endmodule

/* src/hdbf_queue.sv */
// hdbf_queue: short first-in first-out queue between front and back
// depends on hdbf_pkg

module hdbf_queue #(
   parameter int unsigned DATA_W = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              q_full,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data,
   input  logic              pop_take
);
   import hdbf_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !q_full;
   assign do_pop    = pop_take && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/hdbf_back.sv */
// hdbf_back: presence table read-modify-write, clearing pass and result register
// depends on hdbf_pkg

module hdbf_back #(
   parameter int unsigned TABLE_SIZE = hdbf_pkg::TABLE_SIZE_DEFAULT,
   parameter int unsigned SLOT_W     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  logic [SLOT_W:0]           job_data,
   output logic                      job_take,
   output hdbf_pkg::hdbf_status_type back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output hdbf_pkg::hdbf_rsp_type    rsp_payload
);
   import hdbf_pkg::*;

   localparam int unsigned ROW_CNT = TABLE_SIZE / ROW_W;
   localparam int unsigned ROW_AW  = SLOT_W - ROW_BIT_W;

   // presence table
   logic [ROW_W-1:0]  mem [ROW_CNT];
   logic [ROW_W-1:0]  rd_data_ff;

   // clearing pass
   logic              clr_busy_ff, clr_busy_in;
   logic [ROW_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // lookup stage
   logic              b_valid_ff;
   logic [SLOT_W-1:0] b_slot_ff;
   logic              b_record_ff;

   // last row written, for a read that raced the write
   logic              fwd_valid_ff;
   logic [ROW_AW-1:0] fwd_row_ff;
   logic [ROW_W-1:0]  fwd_data_ff;

   // result register
   logic              rsp_valid_ff;
   hdbf_rsp_type      rsp_payload_ff;

   logic              advance;
   logic [ROW_AW-1:0] job_row;
   logic [ROW_AW-1:0] b_row;
   logic [ROW_BIT_W-1:0] b_bit;
   logic [ROW_W-1:0]  row_data;
   logic [ROW_W-1:0]  row_new;
   logic              hit;
   logic              b_write;
   logic              wr_en;
   logic [ROW_AW-1:0] wr_addr;
   logic [ROW_W-1:0]  wr_data;
   logic [31:0]       slot_wide;

   // pipeline moves whenever the result register can take a new value
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign job_take  = advance && job_valid && !clr_busy_ff;
   assign job_row   = job_data[SLOT_W-1:ROW_BIT_W];
   assign back_status.clearing = clr_busy_ff;

   // clearing pass over every row after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == {ROW_AW{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // bit lookup with forwarding of the row written in the read cycle
   assign b_row    = b_slot_ff[SLOT_W-1:ROW_BIT_W];
   assign b_bit    = b_slot_ff[ROW_BIT_W-1:0];
   assign row_data = (fwd_valid_ff && (fwd_row_ff == b_row)) ? fwd_data_ff : rd_data_ff;
   assign hit      = row_data[b_bit];
   assign row_new  = row_data | (ROW_W'(1) << b_bit);
   assign b_write  = advance && b_valid_ff && (b_record_ff == OP_RECORD);

   // single write port: clearing pass or a record
   always_comb begin
      wr_en   = b_write;
      wr_addr = b_row;
      wr_data = row_new;
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         rd_data_ff <= mem[job_row];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // lookup stage and forwarding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff   <= job_take;
         fwd_valid_ff <= b_valid_ff && (b_record_ff == OP_RECORD);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_slot_ff   <= job_data[SLOT_W-1:0];
         b_record_ff <= job_data[SLOT_W];
         fwd_row_ff  <= b_row;
         fwd_data_ff <= row_new;
      end
   end

   // result register
   assign slot_wide = 32'(b_slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.was_present <= hit;
         rsp_payload_ff.slot_index  <= slot_wide[15:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* src/hashed_domain_bit_filter.sv */
// hashed_domain_bit_filter: one-hash membership filter over byte-wise names
// a name's lookup passes the queue, the table read, the lookup stage and the result register
// throughput: one request per cycle while req_stall is low, set by the hash
// update and the table's single read-modify-write per name
// reset: hash cleared, then a clearing pass over all TABLE_SIZE/32 rows (2048 by
// default) during which req_stall is high
// depends on hdbf_pkg, hdbf_front, hdbf_queue, hdbf_back

module hashed_domain_bit_filter #(
   parameter int unsigned TABLE_SIZE = hdbf_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hdbf_pkg::hdbf_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hdbf_pkg::hdbf_rsp_type rsp_payload
);
   import hdbf_pkg::*;

   localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);

   logic            q_full;
   logic            push_valid;
   logic [SLOT_W:0] push_data;
   logic            job_valid;
   logic [SLOT_W:0] job_data;
   logic            job_take;
   hdbf_status_type back_status;

   // byte intake and hashing
   hdbf_front #(.SLOT_W(SLOT_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   // lookups waiting for the table
   hdbf_queue #(.DATA_W(SLOT_W + 1)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full),
      .pop_valid  (job_valid),
      .pop_data   (job_data),
      .pop_take   (job_take)
   );

   // presence table and results
   hdbf_back #(.TABLE_SIZE(TABLE_SIZE), .SLOT_W(SLOT_W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_data    (job_data),
      .job_take    (job_take),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/hdbf_checker.sv */
// hdbf_checker: port-level checks of the hashed domain bit filter
// depends on hdbf_pkg; bound to hashed_domain_bit_filter

module hdbf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input hdbf_pkg::hdbf_req_type req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input hdbf_pkg::hdbf_rsp_type rsp_payload
);
   import hdbf_pkg::*;

   // a stalled request stays offered and holds its value
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed");

   // a stalled result stays and holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // table is being cleared after reset, so no request is taken
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request possible right after reset");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("result without a request after reset");

endmodule

bind hashed_domain_bit_filter hdbf_checker u_hdbf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
